FILE: rtl/bitmap_block_allocator_core_defines.svh
// Assertion macros of the bitmap block allocator RTL.
`ifndef BITMAP_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, idle while reset is high
`define BBA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");
// Next-cycle implication, idle while reset is high
`define BBA_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");
`else
`define BBA_ASSERT_IMP(label, clk, rst, ante, cons)
`define BBA_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/bba_pkg.sv
// Shared types, codes and constants of the bitmap block allocator.
`default_nettype none

package bba_pkg;

  // Default geometry
  localparam int unsigned DEF_POOL_ENTRIES = 2048;
  localparam int unsigned DEF_WORD_BITS    = 32;

  // Fixed field widths
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned IDX_W      = 11;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned START_W    = 11;
  localparam int unsigned RSV_W      = 12;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 12;

  // Register reset values
  localparam logic [START_W-1:0] SEARCH_START_RST   = START_W'(5);
  localparam logic [RSV_W-1:0]   RESERVED_COUNT_RST = RSV_W'(4);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_START   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED_COUNT = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_FORMAT = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Which result the datapath captures this cycle
  typedef enum logic [2:0] {
    RES_NONE  = 3'd0,
    RES_RANGE = 3'd1,
    RES_FULL  = 3'd2,
    RES_FMT   = 3'd3,
    RES_ALLOC = 3'd4,
    RES_FREE  = 3'd5,
    RES_QUERY = 3'd6
  } res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic walk_clr;
    logic walk_step;
    logic rd_en;
    logic fmt_load;
    logic fmt_wr;
    logic idx_load;
    res_t res_sel;
  } bba_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last_word;
    logic located;
    logic idx_range;
    logic hit;
  } bba_stat_t;

endpackage

`default_nettype wire

FILE: rtl/bba_ctrl.sv
// Sequencer of the bitmap block allocator: walks reset clear, format, scan and lookup phases.
`default_nettype none

module bba_ctrl
  import bba_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [CMD_W-1:0] command,
  input  wire bba_stat_t        stat,
  output bba_cmd_t              ctl,
  output logic                  busy,
  output logic                  done
);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_FORMAT = 7'b0000100,
    S_SCAN   = 7'b0001000,
    S_TAIL   = 7'b0010000,
    S_LOCATE = 7'b0100000,
    S_MODIFY = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  cmd_t   op;

  // Next state and datapath commands
  always_comb begin
    state_next    = state;
    ctl           = '0;
    ctl.res_sel   = RES_NONE;
    unique case (state)
      S_CLEAR: begin
        ctl.fmt_wr = 1'b1;
        if (stat.last_word) begin
          state_next = S_IDLE;
        end else begin
          ctl.walk_step = 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          unique case (cmd_t'(command))
            CMD_ALLOC: begin
              ctl.walk_clr = 1'b1;
              state_next   = S_SCAN;
            end
            CMD_FORMAT: begin
              ctl.walk_clr = 1'b1;
              ctl.fmt_load = 1'b1;
              state_next   = S_FORMAT;
            end
            CMD_FREE, CMD_QUERY: begin
              if (stat.idx_range) begin
                ctl.res_sel = RES_RANGE;
              end else begin
                ctl.walk_clr = 1'b1;
                ctl.idx_load = 1'b1;
                state_next   = S_LOCATE;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_FORMAT: begin
        ctl.fmt_wr = 1'b1;
        if (stat.last_word) begin
          ctl.res_sel = RES_FMT;
          state_next  = S_IDLE;
        end else begin
          ctl.walk_step = 1'b1;
        end
      end
      S_SCAN: begin
        if (stat.hit) begin
          ctl.res_sel = RES_ALLOC;
          state_next  = S_IDLE;
        end else begin
          ctl.rd_en = 1'b1;
          if (stat.last_word) begin
            state_next = S_TAIL;
          end else begin
            ctl.walk_step = 1'b1;
          end
        end
      end
      S_TAIL: begin
        ctl.res_sel = stat.hit ? RES_ALLOC : RES_FULL;
        state_next  = S_IDLE;
      end
      S_LOCATE: begin
        if (stat.located) begin
          ctl.rd_en  = 1'b1;
          state_next = S_MODIFY;
        end else begin
          ctl.walk_step = 1'b1;
        end
      end
      S_MODIFY: begin
        ctl.res_sel = (op == CMD_FREE) ? RES_FREE : RES_QUERY;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state and the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (ctl.res_sel != RES_NONE);
    end
  end

  // Capture the operation of an accepted transaction
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op <= cmd_t'(command);
    end
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

FILE: rtl/bba_dpath.sv
// Datapath of the bitmap block allocator: bitmap memory, word walker and result registers.
`default_nettype none

module bba_dpath
  import bba_pkg::*;
#(
  parameter int unsigned POOL_ENTRIES = DEF_POOL_ENTRIES,
  parameter int unsigned WORD_BITS    = DEF_WORD_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire bba_cmd_t              ctl,
  output bba_stat_t                  stat,
  input  wire logic [IDX_W-1:0]      entry_index,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic [STATUS_W-1:0]        status,
  output logic [IDX_W-1:0]           result_index,
  output logic                       entry_used
);

  localparam int unsigned MAP_WORDS = (POOL_ENTRIES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned BW = $clog2(WORD_BITS);
  // Index width: holds the pool size, the configured start and the reserved count
  localparam int unsigned IW = ($clog2(POOL_ENTRIES) > IDX_W) ? $clog2(POOL_ENTRIES) + 1
                                                               : IDX_W + 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_WORDS - 1);
  localparam logic [IW:0]   POOL_X    = (IW + 1)'(POOL_ENTRIES);

  logic [WORD_BITS-1:0] map_mem [MAP_WORDS];

  logic [START_W-1:0]   search_start;
  logic [RSV_W-1:0]     reserved_count;
  logic [IW-1:0]        fmt_n;
  logic [IW-1:0]        idx;
  logic [AW-1:0]        word_addr;
  logic [IW-1:0]        base;
  logic [AW-1:0]        chk_addr;
  logic [IW-1:0]        chk_base;
  logic                 chk_valid;
  logic [WORD_BITS-1:0] rd_data;

  logic [IW:0]          fmt_diff;
  logic [WORD_BITS-1:0] fmt_word;
  logic [IW:0]          lo_diff;
  logic [IW:0]          hi_diff;
  logic [WORD_BITS-1:0] free_bits;
  logic [BW-1:0]        pos_hit;
  logic [BW-1:0]        pos_idx;
  logic [IW-1:0]        alloc_idx;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      search_start   <= SEARCH_START_RST;
      reserved_count <= RESERVED_COUNT_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_SEARCH_START) begin
        search_start <= cfg_data[START_W-1:0];
      end else begin
        reserved_count <= cfg_data[RSV_W-1:0];
      end
    end
  end

  // Latch the saturated reserved count for a format sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      fmt_n <= IW'(RESERVED_COUNT_RST);
    end else if (ctl.fmt_load) begin
      if ({{(IW + 1 - RSV_W){1'b0}}, reserved_count} > POOL_X) begin
        fmt_n <= POOL_X[IW-1:0];
      end else begin
        fmt_n <= IW'(reserved_count);
      end
    end
  end

  // Capture the entry of a free or query transaction
  always_ff @(posedge clk) begin
    if (ctl.idx_load) begin
      idx <= IW'(entry_index);
    end
  end

  // Advance the word walker
  always_ff @(posedge clk) begin
    if (rst || ctl.walk_clr) begin
      word_addr <= '0;
      base      <= '0;
    end else if (ctl.walk_step) begin
      word_addr <= word_addr + AW'(1);
      base      <= base + IW'(WORD_BITS);
    end
  end

  // Track which word the read data belongs to
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_valid <= 1'b0;
    end else begin
      chk_valid <= ctl.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      chk_addr <= word_addr;
      chk_base <= base;
    end
  end

  // Bitmap memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= map_mem[word_addr];
    end
  end

  // Format pattern of the current word
  always_comb begin
    fmt_diff = {1'b0, fmt_n} - {1'b0, base};
    for (int j = 0; j < WORD_BITS; j++) begin
      fmt_word[j] = !fmt_diff[IW] && (fmt_diff > (IW + 1)'(j));
    end
  end

  // Free entries of the checked word inside the search window
  always_comb begin
    lo_diff = {1'b0, IW'(search_start)} - {1'b0, chk_base};
    hi_diff = POOL_X - {1'b0, chk_base};
    for (int j = 0; j < WORD_BITS; j++) begin
      free_bits[j] = !rd_data[j]
                     && (lo_diff[IW] || (lo_diff <= (IW + 1)'(j)))
                     && !hi_diff[IW] && (hi_diff > (IW + 1)'(j));
    end
  end

  // Pick the lowest free entry
  always_comb begin
    pos_hit = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (free_bits[j]) begin
        pos_hit = BW'(j);
      end
    end
  end

  assign alloc_idx = chk_base + IW'(pos_hit);
  assign pos_idx   = BW'(idx - base);

  // Select the memory write
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = word_addr;
    wr_data = fmt_word;
    if (ctl.fmt_wr) begin
      wr_en = 1'b1;
    end else if (ctl.res_sel == RES_ALLOC) begin
      wr_en   = 1'b1;
      wr_addr = chk_addr;
      wr_data = rd_data | (WORD_BITS'(1) << pos_hit);
    end else if (ctl.res_sel == RES_FREE) begin
      wr_en   = 1'b1;
      wr_data = rd_data & ~(WORD_BITS'(1) << pos_idx);
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    unique case (ctl.res_sel)
      RES_RANGE: begin
        status       <= ST_RANGE;
        result_index <= entry_index;
        entry_used   <= 1'b0;
      end
      RES_FULL: begin
        status       <= ST_FULL;
        result_index <= '0;
        entry_used   <= 1'b0;
      end
      RES_FMT: begin
        status       <= ST_OK;
        result_index <= '0;
        entry_used   <= 1'b0;
      end
      RES_ALLOC: begin
        status       <= ST_OK;
        result_index <= alloc_idx[IDX_W-1:0];
        entry_used   <= 1'b1;
      end
      RES_FREE: begin
        status       <= ST_OK;
        result_index <= idx[IDX_W-1:0];
        entry_used   <= 1'b0;
      end
      RES_QUERY: begin
        status       <= ST_OK;
        result_index <= idx[IDX_W-1:0];
        entry_used   <= rd_data[pos_idx];
      end
      default: begin
        status       <= status;
        result_index <= result_index;
        entry_used   <= entry_used;
      end
    endcase
  end

  // Status towards the sequencer
  always_comb begin
    stat.last_word = (word_addr == LAST_ADDR);
    stat.located   = ({1'b0, idx} < ({1'b0, base} + (IW + 1)'(WORD_BITS)));
    stat.idx_range = ({{(IW - IDX_W){1'b0}}, entry_index} >= POOL_X[IW-1:0]);
    stat.hit       = chk_valid && (|free_bits);
  end

endmodule

`default_nettype wire

FILE: rtl/bitmap_block_allocator_core.sv
// Allocate scans the bitmap words in order and answers at the first word with a free
// entry in the search window, or reports full; free/query walk to the entry's word and
// read it; format sweeps every word; an out-of-range free/query index answers without
// raising busy. One transaction at a time: otherwise busy is high from acceptance until
// its result strobe. Reset writes the reset bitmap through the memory port, one word per
// cycle, with busy high. done is high for a single cycle and results cannot be stalled.
`default_nettype none
`include "bitmap_block_allocator_core_defines.svh"

module bitmap_block_allocator_core
  import bba_pkg::*;
#(
  parameter int unsigned POOL_ENTRIES = DEF_POOL_ENTRIES,
  parameter int unsigned WORD_BITS    = DEF_WORD_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [CMD_W-1:0]      command,
  input  wire logic [IDX_W-1:0]      entry_index,
  output logic                       done,
  output logic [STATUS_W-1:0]        status,
  output logic [IDX_W-1:0]           result_index,
  output logic                       entry_used,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  bba_cmd_t  ctl;
  bba_stat_t stat;
  logic      accept;

  assign accept = start && !busy;

  // Sequencer
  bba_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .stat    (stat),
    .ctl     (ctl),
    .busy    (busy),
    .done    (done)
  );

  // Bitmap datapath
  bba_dpath #(
    .POOL_ENTRIES (POOL_ENTRIES),
    .WORD_BITS    (WORD_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .stat         (stat),
    .entry_index  (entry_index),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .status       (status),
    .result_index (result_index),
    .entry_used   (entry_used)
  );

  // An accepted transaction either starts work or answers at once
  `BBA_ASSERT_NXT(a_accept_progress, clk, rst, accept, busy || done)
  // A full pool reports index zero and a clear bit
  `BBA_ASSERT_IMP(a_full_result, clk, rst, done && (status == ST_FULL), (result_index == '0) && !entry_used)
  // An out-of-range transaction reports a clear bit
  `BBA_ASSERT_IMP(a_range_result, clk, rst, done && (status == ST_RANGE), !entry_used)
  // A write-back only happens while a transaction is in flight
  `BBA_ASSERT_IMP(a_write_busy, clk, rst, (ctl.res_sel == RES_ALLOC) || (ctl.res_sel == RES_FREE), busy)

endmodule

`default_nettype wire
